FILE: rtl/great_circle_distance_assert.svh
// Assertion macros for the great-circle distance block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// Same-cycle implication.
`define GCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, widths and constants of the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int COORD_W = 25;
  localparam int DIST_W  = 32;
  localparam int RAD_W   = 16;

  localparam int CORDIC_STAGES = 24;
  localparam int STG_W         = $clog2(CORDIC_STAGES);
  localparam int SQ_STEPS      = 31;
  localparam int SQ_W          = $clog2(SQ_STEPS);

  // CORDIC datapath width, Q30 with headroom
  localparam int CW    = 34;
  localparam int ANG_W = 30;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [60:0] n;
    logic [61:0] res;
  } sq_t;

  localparam coord_t LAT_MAX = 25'sd5898240;
  localparam coord_t LAT_MIN = -25'sd5898240;
  localparam coord_t LON_MAX = 25'sd11796480;
  localparam coord_t LON_MIN = -25'sd11796480;

  localparam logic [63:0] KRAD    = (64'd3141592 << 38) / 64'd180000000;
  localparam logic [15:0] KRAD_LO = KRAD[15:0];
  localparam logic [16:0] KRAD_HI = KRAD[32:16];

  localparam logic signed [CW-1:0] PI_C      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_C = 34'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_C  = 34'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_C    = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_C     = 34'sd1073741824;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd3959;

  localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

endpackage

FILE: rtl/gcd_if.sv
// ----------------------------------------------------------------------------
// gcd_if
// Valid/ready channels of the great-circle distance block.
// ----------------------------------------------------------------------------
interface gcd_in_if import gcd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t lat_a;
  coord_t lon_a;
  coord_t lat_b;
  coord_t lon_b;
  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_out_if import gcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              status;
  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

interface gcd_cfg_if import gcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] sphere_radius;
  modport source (output valid, sphere_radius, input ready);
  modport sink   (input valid, sphere_radius, output ready);
endinterface

FILE: rtl/gcd_rot_cell.sv
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module gcd_rot_cell import gcd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [STG_W-1:0] shift,
  input  logic [ANG_W-1:0] angle,
  input  cordic_t          cin,
  output cordic_t          cout
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] da;
  cordic_t              c_nxt;

  always_comb begin
    dx = cin.y >>> shift;
    dy = cin.x >>> shift;
    da = $signed({{(CW-ANG_W){1'b0}}, angle});
    if (cin.z >= 0) begin
      c_nxt.x = cin.x - dx;
      c_nxt.y = cin.y + dy;
      c_nxt.z = cin.z - da;
    end else begin
      c_nxt.x = cin.x + dx;
      c_nxt.y = cin.y - dy;
      c_nxt.z = cin.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c_nxt;
    end
  end

endmodule

FILE: rtl/gcd_vec_cell.sv
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One vectoring-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module gcd_vec_cell import gcd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [STG_W-1:0] shift,
  input  logic [ANG_W-1:0] angle,
  input  cordic_t          cin,
  output cordic_t          cout
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] da;
  cordic_t              c_nxt;

  always_comb begin
    dx = cin.y >>> shift;
    dy = cin.x >>> shift;
    da = $signed({{(CW-ANG_W){1'b0}}, angle});
    // drive y towards zero, accumulate the angle
    if (cin.y >= 0) begin
      c_nxt.x = cin.x + dx;
      c_nxt.y = cin.y - dy;
      c_nxt.z = cin.z + da;
    end else begin
      c_nxt.x = cin.x - dx;
      c_nxt.y = cin.y + dy;
      c_nxt.z = cin.z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c_nxt;
    end
  end

endmodule

FILE: rtl/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One restoring square-root step: settles one result bit, registered.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] pos,
  input  sq_t             sin,
  output sq_t             sout
);

  logic [61:0] bitv;
  logic [61:0] trial;
  sq_t         s_nxt;

  always_comb begin
    bitv  = 62'd1 << {pos, 1'b0};
    trial = sin.res + bitv;
    if ({1'b0, sin.n} >= trial) begin
      s_nxt.n   = sin.n - trial[60:0];
      s_nxt.res = (sin.res >> 1) + bitv;
    end else begin
      s_nxt.n   = sin.n;
      s_nxt.res = sin.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sout <= s_nxt;
    end
  end

endmodule

FILE: rtl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Spherical law of cosines distance between two lat/lon points.
// ----------------------------------------------------------------------------
// Takes one point pair per clock while ready is high and returns one item per
// pair, in order. From acceptance to the output register the path is:
// six front-end stages (range check, degree-to-radian product in two halves,
// folding), three parallel chains of 24 rotation CORDIC cells for the sines
// and cosines, six product and clamp stages, a chain of 31 square-root cells,
// 24 vectoring CORDIC cells for acos, then the radius product. Every cell
// advances together; a two-entry output buffer lets the pipeline keep taking
// items while a result waits, and only when both entries are full does ready
// drop. Out-of-range coordinates give status 1 and distance 0. The radius
// register is written through the cfg channel and takes effect at the final
// product stage.
module great_circle_distance import gcd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  gcd_in_if.sink  in_ch,
  gcd_out_if.source out_ch,
  gcd_cfg_if.sink cfg_ch
);

  localparam int NV = 6 + CORDIC_STAGES + 6 + SQ_STEPS + CORDIC_STAGES + 2;

  typedef struct packed {
    logic       err;
    logic [2:0] neg;
  } rside_t;

  typedef struct packed {
    logic        err;
    logic        neg;
    logic [30:0] u;
  } sside_t;

  typedef struct packed {
    logic err;
    logic neg;
  } vside_t;

  function automatic logic [30:0] clamp_q30(input logic signed [CW-1:0] v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_C) begin
      r = 31'(ONE_C);
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  logic en;
  logic in_fire;
  logic [NV-1:0] vld_r;
  logic [RAD_W-1:0] radius_r;

  // output buffer
  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_stat_r;
  logic              skid_valid_r;
  logic [DIST_W-1:0] skid_dist_r;
  logic              skid_stat_r;

  assign en           = ~skid_valid_r;
  assign in_ch.ready  = en;
  assign in_fire      = in_ch.valid & en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_ch.valid) begin
      radius_r <= cfg_ch.sphere_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_fire};
    end
  end

  // S1: input register
  coord_t la_r, oa_r, lb_r, ob_r;
  always_ff @(posedge clk) begin
    if (en) begin
      la_r <= in_ch.lat_a;
      oa_r <= in_ch.lon_a;
      lb_r <= in_ch.lat_b;
      ob_r <= in_ch.lon_b;
    end
  end

  // S2: range check, colatitudes and longitude difference
  logic signed [COORD_W:0] cola, colb, dlon, dabs;
  logic                    err2_nxt;
  logic [COORD_W-1:0]      raw_r [3];
  logic                    err2_r;

  always_comb begin
    cola = $signed({LAT_MAX[COORD_W-1], LAT_MAX}) - $signed({la_r[COORD_W-1], la_r});
    colb = $signed({LAT_MAX[COORD_W-1], LAT_MAX}) - $signed({lb_r[COORD_W-1], lb_r});
    dlon = $signed({oa_r[COORD_W-1], oa_r}) - $signed({ob_r[COORD_W-1], ob_r});
    dabs = dlon[COORD_W] ? -dlon : dlon;
    err2_nxt = (la_r > LAT_MAX) || (la_r < LAT_MIN) || (lb_r > LAT_MAX) ||
               (lb_r < LAT_MIN) || (oa_r > LON_MAX) || (oa_r < LON_MIN) ||
               (ob_r > LON_MAX) || (ob_r < LON_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r[0] <= cola[COORD_W-1:0];
      raw_r[1] <= colb[COORD_W-1:0];
      raw_r[2] <= dabs[COORD_W-1:0];
      err2_r   <= err2_nxt;
    end
  end

  // S3: degree-to-radian partial products
  logic [40:0] plo_r [3];
  logic [41:0] phi_r [3];
  logic        err3_r;
  // S4: rounded radians
  logic [57:0]          rsum [3];
  logic signed [CW-1:0] rad4_r [3];
  logic                 err4_r;
  // S5: fold the longitude difference into a half turn
  logic signed [CW-1:0] ang5_r [3];
  logic                 err5_r;
  // S6: quadrant fold
  logic signed [CW-1:0] z6_r [3];
  logic [2:0]           neg6_r;
  logic                 err6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = {phi_r[i], 16'd0} + 58'(plo_r[i]) + 58'(1 << 23);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo_r[i]  <= 41'(raw_r[i]) * 41'(KRAD_LO);
        phi_r[i]  <= 42'(raw_r[i]) * 42'(KRAD_HI);
        rad4_r[i] <= $signed(rsum[i][57:24]);
        if (i == 2 && rad4_r[i] > PI_C) begin
          ang5_r[i] <= TWO_PI_C - rad4_r[i];
        end else begin
          ang5_r[i] <= rad4_r[i];
        end
        if (ang5_r[i] > HALF_PI_C) begin
          z6_r[i]   <= PI_C - ang5_r[i];
          neg6_r[i] <= 1'b1;
        end else begin
          z6_r[i]   <= ang5_r[i];
          neg6_r[i] <= 1'b0;
        end
      end
      err3_r <= err2_r;
      err4_r <= err3_r;
      err5_r <= err4_r;
      err6_r <= err5_r;
    end
  end

  // rotation chains: lane 0 point a, lane 1 point b, lane 2 longitude difference
  cordic_t rc [3][CORDIC_STAGES+1];
  rside_t  rs_r [CORDIC_STAGES];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign rc[l][0] = '{x: GAIN_C, y: '0, z: z6_r[l]};
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      gcd_rot_cell u_cell (
        .clk   (clk),
        .en    (en),
        .shift (STG_W'(s)),
        .angle (ATAN_TAB[s]),
        .cin   (rc[l][s]),
        .cout  (rc[l][s+1])
      );
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rside
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          rs_r[s] <= '{err: err6_r, neg: neg6_r};
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          rs_r[s] <= rs_r[s-1];
        end
      end
    end
  end

  // S7: clamp, apply cosine signs
  logic signed [31:0] c7_r [3];
  logic [30:0]        s7_r [2];
  logic               err7_r;
  // S8..S10: law of cosines
  logic [61:0]        ps8_r;
  logic signed [63:0] pc8_r;
  logic signed [31:0] cd8_r;
  logic               err8_r;
  logic signed [63:0] mt9_r;
  logic signed [31:0] pcs9_r;
  logic               err9_r;
  logic signed [32:0] tsum;
  logic signed [32:0] tcl;
  logic [30:0]        u10_r;
  logic               neg10_r;
  logic               err10_r;
  // S11, S12: 2^60 - t^2
  logic [61:0] usq11_r;
  logic [30:0] u11_r;
  logic        neg11_r;
  logic        err11_r;
  logic [60:0] n12_r;
  logic [30:0] u12_r;
  logic        neg12_r;
  logic        err12_r;

  always_comb begin
    tsum = 33'(mt9_r >>> 30) + 33'(pcs9_r);
    if (tsum > 33'(ONE_C)) begin
      tcl = 33'(ONE_C);
    end else if (tsum < -33'(ONE_C)) begin
      tcl = -33'(ONE_C);
    end else begin
      tcl = tsum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (rs_r[CORDIC_STAGES-1].neg[i]) begin
          c7_r[i] <= -$signed({1'b0, clamp_q30(rc[i][CORDIC_STAGES].x)});
        end else begin
          c7_r[i] <= $signed({1'b0, clamp_q30(rc[i][CORDIC_STAGES].x)});
        end
      end
      s7_r[0] <= clamp_q30(rc[0][CORDIC_STAGES].y);
      s7_r[1] <= clamp_q30(rc[1][CORDIC_STAGES].y);
      err7_r  <= rs_r[CORDIC_STAGES-1].err;

      ps8_r  <= 62'(s7_r[0]) * 62'(s7_r[1]);
      pc8_r  <= 64'(c7_r[0]) * 64'(c7_r[1]);
      cd8_r  <= c7_r[2];
      err8_r <= err7_r;

      mt9_r  <= 64'($signed({1'b0, ps8_r[60:30]})) * 64'(cd8_r);
      pcs9_r <= 32'(pc8_r >>> 30);
      err9_r <= err8_r;

      u10_r   <= tcl[32] ? 31'(-tcl) : tcl[30:0];
      neg10_r <= tcl[32];
      err10_r <= err9_r;

      usq11_r <= 62'(u10_r) * 62'(u10_r);
      u11_r   <= u10_r;
      neg11_r <= neg10_r;
      err11_r <= err10_r;

      n12_r   <= (61'd1 << 60) - usq11_r[60:0];
      u12_r   <= u11_r;
      neg12_r <= neg11_r;
      err12_r <= err11_r;
    end
  end

  // square-root chain, one result bit per cell from the top
  sq_t    sc [SQ_STEPS+1];
  sside_t ss_r [SQ_STEPS];

  assign sc[0] = '{n: n12_r, res: '0};

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    gcd_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .pos  (SQ_W'(SQ_STEPS - 1 - j)),
      .sin  (sc[j]),
      .sout (sc[j+1])
    );
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          ss_r[j] <= '{err: err12_r, neg: neg12_r, u: u12_r};
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          ss_r[j] <= ss_r[j-1];
        end
      end
    end
  end

  // vectoring chain for acos
  cordic_t vc [CORDIC_STAGES+1];
  vside_t  vs_r [CORDIC_STAGES];

  assign vc[0] = '{x: $signed({{(CW-31){1'b0}}, ss_r[SQ_STEPS-1].u}),
                   y: $signed({{(CW-31){1'b0}}, sc[SQ_STEPS].res[30:0]}),
                   z: '0};

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
    gcd_vec_cell u_cell (
      .clk   (clk),
      .en    (en),
      .shift (STG_W'(s)),
      .angle (ATAN_TAB[s]),
      .cin   (vc[s]),
      .cout  (vc[s+1])
    );
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          vs_r[s] <= '{err: ss_r[SQ_STEPS-1].err, neg: ss_r[SQ_STEPS-1].neg};
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          vs_r[s] <= vs_r[s-1];
        end
      end
    end
  end

  // S13: arc, S14: radius product
  logic signed [CW-1:0] zc;
  logic signed [CW-1:0] arc;
  logic [31:0]          arc13_r;
  logic                 err13_r;
  logic [47:0]          prod14_r;
  logic                 err14_r;
  logic [48:0]          rnd;
  logic [DIST_W-1:0]    dist_new;
  logic                 emerge;

  always_comb begin
    if (vc[CORDIC_STAGES].z < 0) begin
      zc = '0;
    end else if (vc[CORDIC_STAGES].z > HALF_PI_C) begin
      zc = HALF_PI_C;
    end else begin
      zc = vc[CORDIC_STAGES].z;
    end
    arc      = vs_r[CORDIC_STAGES-1].neg ? (PI_C - zc) : zc;
    rnd      = {1'b0, prod14_r} + 49'(1 << 21);
    dist_new = err14_r ? '0 : DIST_W'(rnd[48:22]);
    emerge   = vld_r[NV-1] & en;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arc13_r  <= arc[31:0];
      err13_r  <= vs_r[CORDIC_STAGES-1].err;
      prod14_r <= 48'(arc13_r) * 48'(radius_r);
      err14_r  <= err13_r;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ch.ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_ch.ready) begin
      skid_valid_r <= emerge;
    end else begin
      out_valid_r <= emerge;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_dist_r <= skid_dist_r;
        out_stat_r <= skid_stat_r;
      end
    end else if (out_valid_r && !out_ch.ready) begin
      skid_dist_r <= dist_new;
      skid_stat_r <= err14_r;
    end else begin
      out_dist_r <= dist_new;
      out_stat_r <= err14_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.status   = out_stat_r;

endmodule

FILE: rtl/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks of the great-circle distance block.
// ----------------------------------------------------------------------------
module gcd_checker import gcd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] out_distance,
  input logic              out_status
);

`include "great_circle_distance_assert.svh"

  `GCD_ASSERT_NOW(a_err_zero, out_valid && out_status, out_distance == '0, "error item with non-zero distance")
  `GCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_distance) && $stable(out_status), "stalled item changed")
  `GCD_ASSERT_NOW(a_ready_drop, $fell(in_ready), $past(out_valid && !out_ready), "ready dropped without a stalled item")
  `GCD_ASSERT_NOW(a_buffer_full, !in_ready, out_valid, "ready low with empty output register")

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance),
  .out_status   (out_ch.status)
);
